@@ rtl/kts_pkg.sv @@
`timescale 1ns / 1ps

package kts_pkg;

  localparam int KW_MAX_CHARS = 11;
  localparam int NUMBER_BITS  = 32;
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);
  localparam int KW_COUNT     = 31;

  localparam logic [4:0] KIND_EOF    = 5'd0;
  localparam logic [4:0] KIND_COMMA  = 5'd1;
  localparam logic [4:0] KIND_NUMBER = 5'd2;
  localparam logic [4:0] KIND_IDENT  = 5'd3;
  localparam logic [4:0] KIND_LEXERR = 5'd20;

  // Upper-cased 7-bit characters of the current word, entry 0 first.
  typedef logic [KW_MAX_CHARS-1:0][6:0] word_t;

  // Tokens closed by one item: an optional number or word, then an optional
  // comma, lexical error or eof.
  typedef struct packed {
    logic                   has_tok;
    logic                   tok_word;
    logic [NUMBER_BITS-1:0] num_value;
    logic                   num_ovf;
    logic [7:0]             len;
    word_t                  chars;
    logic                   has_sec;
    logic [4:0]             sec_kind;
    logic [15:0]            bad;
  } tok_entry_t;

  // Strings are right-justified in the vector: last character in the low byte.
  localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    "REPEAT",
    "FORWARD", "FD",
    "BACK", "BK",
    "LEFT", "LT",
    "RIGHT", "RT",
    "UP",
    "DOWN", "DN",
    "ROLLRIGHT", "RR",
    "ROLLLEFT", "RL",
    "HOME",
    "MOVETO", "GOTO", "SETPOS",
    "END",
    "CLEARSCREEN", "CLEAR", "CLS", "CLR",
    "PENUP", "PU",
    "PENDOWN", "PD",
    "PENWIDTH", "PW"
  };

  localparam int KW_LEN [KW_COUNT] = '{
    6,
    7, 2,
    4, 2,
    4, 2,
    5, 2,
    2,
    4, 2,
    9, 2,
    8, 2,
    4,
    6, 4, 6,
    3,
    11, 5, 3, 3,
    5, 2,
    7, 2,
    8, 2
  };

  localparam logic [4:0] KW_KIND [KW_COUNT] = '{
    5'd4,
    5'd5, 5'd5,
    5'd6, 5'd6,
    5'd7, 5'd7,
    5'd8, 5'd8,
    5'd9,
    5'd10, 5'd10,
    5'd11, 5'd11,
    5'd12, 5'd12,
    5'd13,
    5'd14, 5'd14, 5'd14,
    5'd15,
    5'd16, 5'd16, 5'd16, 5'd16,
    5'd17, 5'd17,
    5'd18, 5'd18,
    5'd19, 5'd19
  };

  // Parallel compare of a closed word against every table entry.
  function automatic logic [4:0] kw_lookup(input word_t chars, input logic [7:0] len);
    logic [4:0] kind;
    logic       hit;
    int         pos;
    kind = KIND_IDENT;
    for (int e = KW_COUNT - 1; e >= 0; e--) begin
      hit = (len == 8'(KW_LEN[e]));
      for (int i = 0; i < KW_MAX_CHARS; i++) begin
        if (i < KW_LEN[e]) begin
          pos = 8 * (KW_LEN[e] - 1 - i);
          hit = hit && (chars[i] == KW_TEXT[e][pos +: 7]);
        end
      end
      if (hit) begin
        kind = KW_KIND[e];
      end
    end
    return kind;
  endfunction

endpackage

@@ rtl/kts_in_if.sv @@
`timescale 1ns / 1ps

interface kts_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        end_of_input;

  modport source(output valid, char_code, end_of_input, input ready);
  modport sink(input valid, char_code, end_of_input, output ready);
endinterface

@@ rtl/kts_out_if.sv @@
`timescale 1ns / 1ps

interface kts_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] number_value;
  logic        number_overflow;
  logic [7:0]  token_length;
  logic [15:0] bad_char;
  logic        last_result;

  modport source(output valid, token_kind, number_value, number_overflow,
                 token_length, bad_char, last_result, input ready);
  modport sink(input valid, token_kind, number_value, number_overflow,
               token_length, bad_char, last_result, output ready);
endinterface

@@ rtl/kts_front.sv @@
`timescale 1ns / 1ps

module kts_front (
  input  logic               clk,
  input  logic               rst_n,
  kts_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               push,
  output kts_pkg::tok_entry_t push_entry
);
  import kts_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_WORD,
    MODE_ERROR
  } mode_t;

  localparam int NW = NUMBER_BITS + 4;

  mode_t                  mode_r, mode_nxt;
  logic [7:0]             count_r, count_nxt;
  logic [NUMBER_BITS-1:0] acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;
  word_t                  chars_r;

  logic                   fire;
  logic [15:0]            c;
  logic                   is_digit, is_letter, is_blank, is_wchar;
  logic [6:0]             up_char;
  logic [NW-1:0]          acc_x10;
  logic                   acc_sat;
  logic                   wr_char;
  logic [7:0]             wr_idx;
  logic [7:0]             count_inc;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign c           = in_ch.char_code;

  always_comb begin
    is_digit  = c inside {[16'h0030:16'h0039]};
    is_letter = c inside {[16'h0041:16'h005A], [16'h0061:16'h007A]};
    is_blank  = c inside {16'h0020, [16'h0009:16'h000D]};
    is_wchar  = is_letter || is_digit || (c == 16'h005F);
    up_char   = (c inside {[16'h0061:16'h007A]}) ? (c[6:0] - 7'd32) : c[6:0];
    acc_x10   = (NW'(acc_r) << 3) + (NW'(acc_r) << 1) + NW'(c[3:0]);
    acc_sat   = ovf_r || (|acc_x10[NW-1:NUMBER_BITS]);
    count_inc = (count_r == 8'hFF) ? count_r : count_r + 8'd1;
  end

  always_comb begin
    mode_nxt   = mode_r;
    count_nxt  = count_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    wr_char    = 1'b0;
    wr_idx     = count_r;
    push_entry = '0;
    push_entry.num_value = acc_r;
    push_entry.num_ovf   = ovf_r;
    push_entry.len       = count_r;
    push_entry.chars     = chars_r;
    push_entry.tok_word  = (mode_r == MODE_WORD);

    if (fire) begin
      if (in_ch.end_of_input) begin
        push_entry.has_tok  = (mode_r == MODE_NUMBER) || (mode_r == MODE_WORD);
        push_entry.has_sec  = 1'b1;
        push_entry.sec_kind = KIND_EOF;
        mode_nxt            = MODE_IDLE;
      end else if (mode_r == MODE_ERROR) begin
        // swallow everything up to the end marker
      end else if (mode_r == MODE_NUMBER && is_digit) begin
        acc_nxt   = acc_sat ? '1 : acc_x10[NUMBER_BITS-1:0];
        ovf_nxt   = acc_sat;
        count_nxt = count_inc;
      end else if (mode_r == MODE_WORD && is_wchar) begin
        wr_char   = (count_r < 8'(KW_MAX_CHARS));
        count_nxt = count_inc;
      end else begin
        // this character closes any pending token, then acts as in idle
        push_entry.has_tok = (mode_r == MODE_NUMBER) || (mode_r == MODE_WORD);
        mode_nxt           = MODE_IDLE;
        if (c == 16'h002C) begin
          push_entry.has_sec  = 1'b1;
          push_entry.sec_kind = KIND_COMMA;
        end else if (is_digit) begin
          mode_nxt  = MODE_NUMBER;
          acc_nxt   = NUMBER_BITS'(c[3:0]);
          ovf_nxt   = 1'b0;
          count_nxt = 8'd1;
        end else if (is_letter) begin
          mode_nxt  = MODE_WORD;
          wr_char   = 1'b1;
          wr_idx    = 8'd0;
          count_nxt = 8'd1;
        end else if (!is_blank) begin
          push_entry.has_sec  = 1'b1;
          push_entry.sec_kind = KIND_LEXERR;
          push_entry.bad      = c;
          mode_nxt            = MODE_ERROR;
        end
      end
    end
    push = push_entry.has_tok || push_entry.has_sec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      count_r <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < KW_MAX_CHARS; i++) begin
      if (wr_char && wr_idx == 8'(i)) begin
        chars_r[i] <= up_char;
      end
    end
  end

`ifndef SYNTHESIS
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !in_ch.end_of_input && mode_r == MODE_ERROR) |-> !push)
    else $error("item in error mode produced a token");
`endif

endmodule

@@ rtl/kts_queue.sv @@
`timescale 1ns / 1ps

module kts_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  kts_pkg::tok_entry_t push_entry,
  input  logic                pop,
  output logic                head_valid,
  output kts_pkg::tok_entry_t head_entry,
  output logic                full
);
  import kts_pkg::*;

  tok_entry_t     slots_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push, do_pop;

  assign full       = (count_r == (QAW + 1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r + (QAW + 1)'(do_push) - (QAW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW + 1)'(QDEPTH))
    else $error("queue count past depth");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue drops an item");
`endif

endmodule

@@ rtl/kts_back.sv @@
`timescale 1ns / 1ps

module kts_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  kts_pkg::tok_entry_t head_entry,
  output logic                pop,
  kts_out_if.source           out_ch
);
  import kts_pkg::*;

  logic        phase_r, phase_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  kind_r, kind_nxt;
  logic [31:0] value_r, value_nxt;
  logic        ovf_r, ovf_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] bad_r, bad_nxt;
  logic        last_r, last_nxt;
  logic        emit_tok, load;

  always_comb begin
    emit_tok = head_entry.has_tok && !phase_r;
    load     = head_valid && (!out_valid_r || out_ch.ready);
    pop      = load && !(emit_tok && head_entry.has_sec);

    phase_nxt     = load ? (emit_tok && head_entry.has_sec) : phase_r;
    out_valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

    if (emit_tok) begin
      if (head_entry.tok_word) begin
        kind_nxt  = kw_lookup(head_entry.chars, head_entry.len);
        value_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        kind_nxt  = KIND_NUMBER;
        value_nxt = 32'(head_entry.num_value);
        ovf_nxt   = head_entry.num_ovf;
      end
      len_nxt  = head_entry.len;
      bad_nxt  = '0;
      last_nxt = !head_entry.has_sec;
    end else begin
      kind_nxt  = head_entry.sec_kind;
      value_nxt = '0;
      ovf_nxt   = 1'b0;
      len_nxt   = '0;
      bad_nxt   = head_entry.bad;
      last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      ovf_r   <= ovf_nxt;
      len_r   <= len_nxt;
      bad_r   <= bad_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.token_kind      = kind_r;
  assign out_ch.number_value    = value_r;
  assign out_ch.number_overflow = ovf_r;
  assign out_ch.token_length    = len_r;
  assign out_ch.bad_char        = bad_r;
  assign out_ch.last_result     = last_r;

`ifndef SYNTHESIS
  a_phase_pair: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (head_valid && head_entry.has_tok && head_entry.has_sec))
    else $error("second-result phase without a two-token entry");
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_EOF) |-> last_r)
    else $error("eof item not flagged as last");
`endif

endmodule

@@ rtl/keyword_token_scanner.sv @@
// Path: an accepted item waits in the 4-entry token queue, which absorbs
// output stalls, until its results are loaded into the output register.
// Throughput: one input item per cycle while the token queue is not full;
// the output register delivers one result per cycle while the sink is ready,
// so an item that closes a token and adds a comma, error or eof gives two.
// Reset: synchronous active-low rst_n clears scan mode, counters, queue and
// output valid; the word character buffer is not cleared.
`timescale 1ns / 1ps

module keyword_token_scanner (
  input  logic      clk,
  input  logic      rst_n,
  kts_in_if.sink    in_ch,
  kts_out_if.source out_ch
);
  import kts_pkg::*;

  logic       push, pop, full, head_valid;
  tok_entry_t push_entry, head_entry;

  kts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (full),
    .push       (push),
    .push_entry (push_entry)
  );

  kts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .full       (full)
  );

  kts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import kts_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AFTER  = 150;
  localparam int HOLD_CYCLES = 300;

  // Keyword token kinds
  localparam logic [4:0] TOK_REPEAT    = 5'd4;
  localparam logic [4:0] TOK_FORWARD   = 5'd5;
  localparam logic [4:0] TOK_BACK      = 5'd6;
  localparam logic [4:0] TOK_LEFT      = 5'd7;
  localparam logic [4:0] TOK_RIGHT     = 5'd8;
  localparam logic [4:0] TOK_UP        = 5'd9;
  localparam logic [4:0] TOK_DOWN      = 5'd10;
  localparam logic [4:0] TOK_ROLLRIGHT = 5'd11;
  localparam logic [4:0] TOK_ROLLLEFT  = 5'd12;
  localparam logic [4:0] TOK_HOME      = 5'd13;
  localparam logic [4:0] TOK_MOVETO    = 5'd14;
  localparam logic [4:0] TOK_END       = 5'd15;
  localparam logic [4:0] TOK_CLEAR     = 5'd16;
  localparam logic [4:0] TOK_PENUP     = 5'd17;
  localparam logic [4:0] TOK_PENDOWN   = 5'd18;
  localparam logic [4:0] TOK_PENWIDTH  = 5'd19;

  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_CR    = 16'h000D;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_COMMA = 16'h002C;
  localparam logic [15:0] CH_0     = 16'h0030;
  localparam logic [15:0] CH_9     = 16'h0039;
  localparam logic [15:0] CH_UA    = 16'h0041;
  localparam logic [15:0] CH_UZ    = 16'h005A;
  localparam logic [15:0] CH_UNDER = 16'h005F;
  localparam logic [15:0] CH_LA    = 16'h0061;
  localparam logic [15:0] CH_LZ    = 16'h007A;
  localparam logic [15:0] CH_DEL   = 16'h007F;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_WORD, SCAN_ERROR} scan_mode_e;

  typedef struct {
    logic [4:0]  kind;
    logic [31:0] value;
    logic        ovf;
    logic [7:0]  len;
    logic [15:0] bad;
    logic        last;
  } token_t;

  typedef struct {
    logic [15:0] code;
    logic        eoi;
  } char_item_t;

  class token_ledger;
    token_t     expected_tokens[$];
    int         mismatches;
    scan_mode_e mode;
    string      word_text;
    logic [7:0] char_count;
    logic [31:0] accum;
    logic       accum_ovf;

    function new();
      mode       = SCAN_IDLE;
      word_text  = "";
      char_count = 8'd0;
      accum      = 32'd0;
      accum_ovf  = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    function bit is_digit(logic [15:0] c);
      return c >= CH_0 && c <= CH_9;
    endfunction

    function bit is_letter(logic [15:0] c);
      return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
    endfunction

    function void add_token(logic [4:0] kind, logic [31:0] value, logic ovf,
                            logic [7:0] len, logic [15:0] bad);
      token_t t;
      t.kind  = kind;
      t.value = value;
      t.ovf   = ovf;
      t.len   = len;
      t.bad   = bad;
      t.last  = 1'b0;
      expected_tokens.push_back(t);
    endfunction

    function logic [4:0] keyword_kind();
      if (char_count > KW_MAX_CHARS) return KIND_IDENT;
      case (word_text)
        "REPEAT":                              return TOK_REPEAT;
        "FORWARD", "FD":                       return TOK_FORWARD;
        "BACK", "BK":                          return TOK_BACK;
        "LEFT", "LT":                          return TOK_LEFT;
        "RIGHT", "RT":                         return TOK_RIGHT;
        "UP":                                  return TOK_UP;
        "DOWN", "DN":                          return TOK_DOWN;
        "ROLLRIGHT", "RR":                     return TOK_ROLLRIGHT;
        "ROLLLEFT", "RL":                      return TOK_ROLLLEFT;
        "HOME":                                return TOK_HOME;
        "MOVETO", "GOTO", "SETPOS":            return TOK_MOVETO;
        "END":                                 return TOK_END;
        "CLEARSCREEN", "CLEAR", "CLS", "CLR":  return TOK_CLEAR;
        "PENUP", "PU":                         return TOK_PENUP;
        "PENDOWN", "PD":                       return TOK_PENDOWN;
        "PENWIDTH", "PW":                      return TOK_PENWIDTH;
        default:                               return KIND_IDENT;
      endcase
    endfunction

    function void close_token();
      if (mode == SCAN_NUMBER)
        add_token(KIND_NUMBER, accum, accum_ovf, char_count, 16'd0);
      else if (mode == SCAN_WORD)
        add_token(keyword_kind(), 32'd0, 1'b0, char_count, 16'd0);
      if (mode != SCAN_ERROR) mode = SCAN_IDLE;
    endfunction

    function void take_char(logic [15:0] c, logic eoi);
      int          n_prior;
      logic [63:0] grown;
      logic [7:0]  up;
      n_prior = expected_tokens.size();
      up = (c >= CH_LA && c <= CH_LZ) ? c[7:0] - 8'd32 : c[7:0];
      if (eoi) begin
        close_token();
        add_token(KIND_EOF, 32'd0, 1'b0, 8'd0, 16'd0);
        mode = SCAN_IDLE;
      end else if (mode == SCAN_ERROR) begin
        // swallowed until the end marker
      end else if (mode == SCAN_NUMBER && is_digit(c)) begin
        grown = {32'd0, accum} * 64'd10 + {48'd0, c - CH_0};
        if (accum_ovf || grown > 64'hFFFF_FFFF) begin
          accum     = '1;
          accum_ovf = 1'b1;
        end else begin
          accum = grown[31:0];
        end
        if (char_count < 8'd255) char_count++;
      end else if (mode == SCAN_WORD && (is_letter(c) || is_digit(c) || c == CH_UNDER)) begin
        if (char_count < KW_MAX_CHARS) word_text = $sformatf("%s%c", word_text, up);
        if (char_count < 8'd255) char_count++;
      end else begin
        close_token();
        if (c == CH_COMMA) begin
          add_token(KIND_COMMA, 32'd0, 1'b0, 8'd0, 16'd0);
        end else if (is_digit(c)) begin
          mode       = SCAN_NUMBER;
          accum      = 32'(c - CH_0);
          accum_ovf  = 1'b0;
          char_count = 8'd1;
        end else if (is_letter(c)) begin
          mode       = SCAN_WORD;
          word_text  = $sformatf("%c", up);
          char_count = 8'd1;
        end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
          add_token(KIND_LEXERR, 32'd0, 1'b0, 8'd0, c);
          mode = SCAN_ERROR;
        end
      end
      if (expected_tokens.size() > n_prior)
        expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        mismatches++;
      end
    endfunction

    function void match_token(token_t got);
      token_t want;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual kind %0d", $time, got.kind);
        mismatches++;
        return;
      end
      want = expected_tokens.pop_front();
      check_field("token_kind", want.kind, got.kind);
      check_field("number_value", want.value, got.value);
      check_field("number_overflow", want.ovf, got.ovf);
      check_field("token_length", want.len, got.len);
      check_field("bad_char", want.bad, got.bad);
      check_field("last_result", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  bit   sink_holding = 1'b0;

  kts_in_if  in_ch ();
  kts_out_if out_ch ();

  keyword_token_scanner u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  token_ledger ledger;
  char_item_t  char_stream[$];

  string kw_names[] = '{
    "REPEAT", "FORWARD", "FD", "BACK", "BK", "LEFT", "LT", "RIGHT", "RT", "UP",
    "DOWN", "DN", "ROLLRIGHT", "RR", "ROLLLEFT", "RL", "HOME", "MOVETO", "GOTO",
    "SETPOS", "END", "CLEARSCREEN", "CLEAR", "CLS", "CLR", "PENUP", "PU",
    "PENDOWN", "PD", "PENWIDTH", "PW"
  };

  string big_numbers[] = '{
    "4294967295", "4294967296", "4294967300", "0", "00000000000042",
    "18446744073709551616"
  };

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void push_code(logic [15:0] c);
    char_item_t it;
    it.code = c;
    it.eoi  = 1'b0;
    char_stream.push_back(it);
  endfunction

  function automatic void push_end();
    char_item_t it;
    it.code = 16'($urandom_range(0, 65535));
    it.eoi  = 1'b1;
    char_stream.push_back(it);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_code({8'h00, s.getc(i)});
  endfunction

  function automatic logic [15:0] random_letter();
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 16'($urandom_range(0, 25));
  endfunction

  function automatic string mix_case(string w);
    string s;
    s = w;
    for (int i = 0; i < s.len(); i++)
      if ($urandom_range(0, 1)) s.putc(i, s.getc(i) + 8'd32);
    return s;
  endfunction

  function automatic void push_ident();
    int n;
    int r;
    n = $urandom_range(0, 13);
    push_code(random_letter());
    repeat (n) begin
      r = $urandom_range(0, 62);
      if (r < 52) push_code(random_letter());
      else if (r < 62) push_code(CH_0 + 16'($urandom_range(0, 9)));
      else push_code(CH_UNDER);
    end
  endfunction

  function automatic void push_number();
    int n;
    if ($urandom_range(0, 9) == 0) begin
      push_text(big_numbers[$urandom_range(0, big_numbers.size() - 1)]);
    end else begin
      n = $urandom_range(1, 11);
      repeat (n) push_code(CH_0 + 16'($urandom_range(0, 9)));
    end
  endfunction

  function automatic logic [15:0] pick_bad();
    string punct;
    punct = "!\"#$%&'()*+-./:;<=>?@[\\]^_`{|}~";
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(128, 65535));
      1:       return 16'($urandom_range(0, 8));
      2:       return {8'h00, punct.getc($urandom_range(0, punct.len() - 1))};
      default: return $urandom_range(0, 1) ? CH_DEL : 16'($urandom_range(14, 31));
    endcase
  endfunction

  function automatic void push_blank();
    int r;
    repeat ($urandom_range(1, 2)) begin
      r = $urandom_range(0, 6);
      push_code(r < 5 ? CH_TAB + 16'(r) : CH_SPACE);
    end
  endfunction

  // One statement of text ended by the end marker; a few are pure noise.
  function automatic void build_program();
    int n_tok;
    int r;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(3, 15))
        push_code($urandom_range(0, 1) ? 16'($urandom_range(0, 127))
                                       : 16'($urandom_range(0, 65535)));
    end else begin
      n_tok = $urandom_range(1, 10);
      repeat (n_tok) begin
        r = $urandom_range(0, 99);
        if (r < 35) push_text(mix_case(kw_names[$urandom_range(0, kw_names.size() - 1)]));
        else if (r < 50) push_ident();
        else if (r < 78) push_number();
        else if (r < 90) push_code(CH_COMMA);
        else if (r < 95) push_code(pick_bad());
        else push_blank();
        // token separator: blank, comma or nothing at all
        r = $urandom_range(0, 99);
        if (r < 55) push_blank();
        else if (r < 70) push_code(CH_COMMA);
      end
    end
    push_end();
  endfunction

  // Word or number past the 255-character length cap.
  function automatic void push_long_token(bit as_number);
    int n;
    n = $urandom_range(256, 262);
    for (int i = 0; i < n; i++)
      push_code(as_number ? CH_0 + 16'($urandom_range(0, 9)) : random_letter());
    push_end();
  endfunction

  task automatic send_stream();
    int         gap;
    int         burst_left;
    bit         no_gap;
    char_item_t it;
    burst_left = 0;
    no_gap     = 1'b0;
    foreach (char_stream[i]) begin
      it = char_stream[i];
      if (burst_left == 0) begin
        no_gap     = ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(20, 120);
      end else begin
        burst_left--;
      end
      gap = (no_gap || sink_holding) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid        <= 1'b1;
      in_ch.char_code    <= it.code;
      in_ch.end_of_input <= it.eoi;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      ledger.take_char(it.code, it.eoi);
    end
    in_ch.valid <= 1'b0;
  endtask

  // Result side: random stalls, idle-free stretches and one long hold-off.
  initial begin : result_sink
    int     stall_left;
    int     hold_left;
    int     burst_left;
    int     tokens_seen;
    bit     no_stall;
    bit     hold_done;
    token_t got;
    stall_left  = 0;
    hold_left   = 0;
    burst_left  = 0;
    tokens_seen = 0;
    no_stall    = 1'b0;
    hold_done   = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.kind  = out_ch.token_kind;
        got.value = out_ch.number_value;
        got.ovf   = out_ch.number_overflow;
        got.len   = out_ch.token_length;
        got.bad   = out_ch.bad_char;
        got.last  = out_ch.last_result;
        ledger.match_token(got);
        tokens_seen++;
        if (burst_left == 0) begin
          no_stall   = ($urandom_range(0, 3) == 0);
          burst_left = $urandom_range(10, 60);
        end else begin
          burst_left--;
        end
        stall_left = no_stall ? 0 : $urandom_range(0, 12);
        if (!hold_done && tokens_seen == HOLD_AFTER) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      sink_holding = (hold_left > 0);
      out_ch.ready <= (hold_left == 0 && stall_left == 0);
    end
  end

  initial begin
    ledger = new();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.char_code    <= 16'd0;
    in_ch.end_of_input <= 1'b0;

    // keyword closed by comma, overflowing number closed by the end marker
    push_text("fD,4294967296");
    push_end();
    // number closed by a letter, word closed by a lexical error, then ignored text
    push_text("0z");
    push_code(16'hFFFF);
    push_text("a");
    push_end();
    // fresh start after end of file; blank closes the alias
    push_text("pw ");
    push_end();

    while (char_stream.size() < 1100) build_program();
    push_long_token(1'b0);
    push_long_token(1'b1);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_stream();
    while (ledger.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (ledger.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/kts_pkg.sv
rtl/kts_in_if.sv
rtl/kts_out_if.sv
rtl/kts_front.sv
rtl/kts_queue.sv
rtl/kts_back.sv
rtl/keyword_token_scanner.sv
bench/tb_top.sv
